FILE: hw/rtl/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Shared constants and types for the byte string search block.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int NEEDLE_MAX_DEF  = 32;
  localparam int OFFSET_BITS_DEF = 32;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 6;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int WORD_BYTES  = 8;
  localparam int MATCH_OFF_W = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_WORD_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_WORD_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_LENGTH = 3'd4;

  localparam logic [LEN_W-1:0] NEEDLE_LENGTH_RST = 6'd1;

  typedef struct packed {
    logic                   found;
    logic [MATCH_OFF_W-1:0] match_offset;
  } result_t;

endpackage

FILE: hw/rtl/byte_string_search_top.sv
// ----------------------------------------------------------------------------
// byte_string_search_top
// First-occurrence search of a configured needle in a streamed haystack.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall   haystack_byte, is_last
//  out      out_valid / out_stall found, match_offset
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  one haystack beat per cycle while in_stall is low; the window compare finishes in the accept cycle
//  a result is registered in the output register, or in the skid entry when a valid output
//  is held by out_stall; this two-entry output buffer lets input flow while a result waits;
//  in_stall rises only when both entries are full, and during reset
//  reset is synchronous; cfg_ready is always high
// ----------------------------------------------------------------------------
module byte_string_search_top #(
  parameter int NEEDLE_MAX  = bss_pkg::NEEDLE_MAX_DEF,
  parameter int OFFSET_BITS = bss_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bss_pkg::BYTE_W-1:0]         haystack_byte,
  input  logic                               is_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               found,
  output logic [bss_pkg::MATCH_OFF_W-1:0]    match_offset,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bss_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [NEEDLE_MAX-1:0][bss_pkg::BYTE_W-1:0] needle;
  logic [bss_pkg::LEN_W-1:0]                  needle_len;

  logic [NEEDLE_MAX-1:0][bss_pkg::BYTE_W-1:0] window;
  logic [NEEDLE_MAX-1:0][bss_pkg::BYTE_W-1:0] window_next;
  logic [OFFSET_BITS-1:0]                     count;
  logic [OFFSET_BITS-1:0]                     count_next;
  logic                                       match_seen;
  logic                                       match_seen_next;
  logic [OFFSET_BITS-1:0]                     first_offset;
  logic [OFFSET_BITS-1:0]                     first_offset_next;

  logic             hit;
  logic             in_beat;
  logic             new_res;
  bss_pkg::result_t res_new;
  bss_pkg::result_t out_res;
  bss_pkg::result_t pend_res;
  logic             pend_valid;

  assign cfg_ready = 1'b1;
  assign in_stall  = pend_valid | rst;
  assign in_beat   = in_valid & ~in_stall;
  assign new_res   = in_beat & is_last;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      needle     <= '0;
      needle_len <= bss_pkg::NEEDLE_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bss_pkg::CFG_NEEDLE_LENGTH) begin
        needle_len <= cfg_data[bss_pkg::LEN_W-1:0];
      end
      for (int k = 0; k < NEEDLE_MAX; k++) begin
        if ((cfg_index <= bss_pkg::CFG_NEEDLE_WORD_3) &&
            (cfg_index == bss_pkg::CFG_INDEX_W'(k / bss_pkg::WORD_BYTES))) begin
          needle[k] <= cfg_data[(k % bss_pkg::WORD_BYTES)*bss_pkg::BYTE_W +: bss_pkg::BYTE_W];
        end
      end
    end
  end

  always_comb begin
    window_next[0] = haystack_byte;
    for (int i = 1; i < NEEDLE_MAX; i++) begin
      window_next[i] = window[i-1];
    end
    count_next = (count == '1) ? count : count + 1'b1;
  end

  bss_match #(
    .NEEDLE_MAX(NEEDLE_MAX)
  ) u_match (
    .window (window_next),
    .needle (needle),
    .len    (needle_len),
    .hit    (hit)
  );

  always_comb begin
    match_seen_next   = match_seen;
    first_offset_next = first_offset;
    if (!match_seen) begin
      if (needle_len == '0) begin
        match_seen_next   = 1'b1;
        first_offset_next = '0;
      end else if (hit && (count_next >= OFFSET_BITS'(needle_len))) begin
        match_seen_next   = 1'b1;
        first_offset_next = count_next - OFFSET_BITS'(needle_len);
      end
    end
    res_new.found        = match_seen_next;
    res_new.match_offset = match_seen_next ?
                           bss_pkg::MATCH_OFF_W'(first_offset_next) : '0;
  end

  // search state; window needs no reset since the count gates every compare
  always_ff @(posedge clk) begin
    if (in_beat) begin
      window <= window_next;
    end
    if (rst) begin
      count        <= '0;
      match_seen   <= 1'b0;
      first_offset <= '0;
    end else if (in_beat) begin
      if (is_last) begin
        count        <= '0;
        match_seen   <= 1'b0;
        first_offset <= '0;
      end else begin
        count        <= count_next;
        match_seen   <= match_seen_next;
        first_offset <= first_offset_next;
      end
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        out_res    <= pend_res;
        pend_valid <= 1'b0;
      end else begin
        out_valid <= new_res;
        out_res   <= res_new;
      end
    end else if (new_res) begin
      pend_valid <= 1'b1;
      pend_res   <= res_new;
    end
  end

  assign found        = out_res.found;
  assign match_offset = out_res.match_offset;

endmodule

FILE: hw/rtl/bss_match.sv
// ----------------------------------------------------------------------------
// bss_match
// Compare of the newest len window bytes against the needle, for len 1 to NEEDLE_MAX.
// ----------------------------------------------------------------------------
module bss_match #(
  parameter int NEEDLE_MAX = bss_pkg::NEEDLE_MAX_DEF
) (
  input  logic [NEEDLE_MAX-1:0][bss_pkg::BYTE_W-1:0] window,
  input  logic [NEEDLE_MAX-1:0][bss_pkg::BYTE_W-1:0] needle,
  input  logic [bss_pkg::LEN_W-1:0]                  len,
  output logic                                       hit
);

  localparam int FLAT_W = NEEDLE_MAX * bss_pkg::BYTE_W;

  logic [NEEDLE_MAX-1:0][bss_pkg::BYTE_W-1:0] rev;
  logic [NEEDLE_MAX-1:0][bss_pkg::BYTE_W-1:0] aligned;
  logic [bss_pkg::LEN_W-1:0]                  shift_bytes;
  logic                                       len_ok;

  // needle reversed, then shifted so that needle byte 0 sits at window slot len-1
  always_comb begin
    for (int k = 0; k < NEEDLE_MAX; k++) begin
      rev[k] = needle[NEEDLE_MAX-1-k];
    end
    shift_bytes = bss_pkg::LEN_W'(NEEDLE_MAX) - len;
    aligned     = FLAT_W'(rev) >> {shift_bytes, 3'b000};
  end

  assign len_ok = (len != '0) && (len <= bss_pkg::LEN_W'(NEEDLE_MAX));

  always_comb begin
    hit = len_ok;
    for (int j = 0; j < NEEDLE_MAX; j++) begin
      if ((bss_pkg::LEN_W'(j) < len) && (window[j] != aligned[j])) begin
        hit = 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/bss_checker.sv
// ----------------------------------------------------------------------------
// bss_checker
// Port-level checks for the byte string search block, bound to the top.
// ----------------------------------------------------------------------------
module bss_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            is_last,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            found,
  input logic [bss_pkg::MATCH_OFF_W-1:0] match_offset
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(match_offset))
    else $error("result beat changed while stalled");

  // no offset without a match
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_offset == '0)
    else $error("nonzero offset on a miss");

  // a fresh result follows a last input beat
  a_res_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && is_last))
    else $error("result without a last beat");

  // input only backs up when a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && $past(out_valid && out_stall))
    else $error("input stalled with no waiting result");

endmodule

bind byte_string_search_top bss_checker u_bss_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .is_last      (is_last),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .found        (found),
  .match_offset (match_offset)
);

FILE: verif/byte_string_search_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_string_search_top_test
// Self-checking bench for the streamed first-occurrence byte string search.
// Haystack beats are fed from a queue by a clocked driver. A predictor keeps
// its own window, count and needle copy, and it queues one expected report
// per haystack. A clocked monitor takes each report and compares it field by
// field. Random haystacks mostly use bytes drawn from the needle, often with
// the needle planted, so that both hits and near misses are common. The needle
// changes between haystacks and sometimes in the middle of one. Both sides
// stall at random, and a long output hold fills the block until it stalls.
// ----------------------------------------------------------------------------
module byte_string_search_top_test;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int RUN_ITEMS    = 600;
  localparam int NEEDLE_W     = bss_pkg::NEEDLE_MAX_DEF * bss_pkg::BYTE_W;
  localparam int LEN_TOP      = (1 << bss_pkg::LEN_W) - 1;

  localparam logic [bss_pkg::CFG_INDEX_W-1:0] CFG_SPARE_FIRST =
    bss_pkg::CFG_NEEDLE_LENGTH + bss_pkg::CFG_INDEX_W'(1);
  localparam logic [bss_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LAST  = '1;

  typedef struct packed {
    logic [bss_pkg::BYTE_W-1:0] data;
    logic                       last;
  } beat_t;

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_stall;
  logic [bss_pkg::BYTE_W-1:0]      haystack_byte;
  logic                            is_last;
  logic                            out_valid;
  logic                            out_stall;
  logic                            found;
  logic [bss_pkg::MATCH_OFF_W-1:0] match_offset;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [bss_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bss_pkg::CFG_DATA_W-1:0]  cfg_data;

  beat_t            haystack_q [$];
  bss_pkg::result_t expected_reports [$];
  beat_t            next_beat;
  bss_pkg::result_t want;

  // predictor state
  logic [bss_pkg::BYTE_W-1:0]          win [bss_pkg::NEEDLE_MAX_DEF];
  logic [bss_pkg::OFFSET_BITS_DEF-1:0] seen_count;
  logic                                hit_seen;
  logic [bss_pkg::OFFSET_BITS_DEF-1:0] hit_offset;
  logic [bss_pkg::CFG_DATA_W-1:0]      needle_words [4];
  logic [bss_pkg::LEN_W-1:0]           needle_len;

  // stimulus side copy of the needle
  logic [NEEDLE_W-1:0] gen_bits;
  int                  gen_len = 1;

  int items_sent     = 0;
  int accepted_count = 0;
  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_asked     = 0;
  int hold_given     = 0;
  int hold_left      = 0;

  byte_string_search_top DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .haystack_byte (haystack_byte),
    .is_last       (is_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .match_offset  (match_offset),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic void clear_search_state();
    for (int i = 0; i < bss_pkg::NEEDLE_MAX_DEF; i++) win[i] = '0;
    seen_count = '0;
    hit_seen   = 1'b0;
    hit_offset = '0;
  endfunction

  function automatic void search_byte(input logic [bss_pkg::BYTE_W-1:0] b, input logic last);
    int                         len;
    bit                         same;
    logic [bss_pkg::BYTE_W-1:0] nb;
    bss_pkg::result_t           r;
    len = int'(needle_len);
    for (int i = bss_pkg::NEEDLE_MAX_DEF - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = b;
    if (seen_count != '1) seen_count++;
    if (!hit_seen) begin
      if (len == 0) begin
        hit_seen   = 1'b1;
        hit_offset = '0;
      end else if (len <= bss_pkg::NEEDLE_MAX_DEF && seen_count >= len) begin
        same = 1'b1;
        for (int i = 0; i < len; i++) begin
          nb = needle_words[i / bss_pkg::WORD_BYTES]
                           [(i % bss_pkg::WORD_BYTES) * bss_pkg::BYTE_W +: bss_pkg::BYTE_W];
          if (win[len-1-i] != nb)
            same = 1'b0;
        end
        if (same) begin
          hit_seen   = 1'b1;
          hit_offset = seen_count - bss_pkg::OFFSET_BITS_DEF'(len);
        end
      end
    end
    if (last) begin
      r.found        = hit_seen;
      r.match_offset = hit_seen ? hit_offset[bss_pkg::MATCH_OFF_W-1:0] : '0;
      expected_reports.push_back(r);
      clear_search_state();
    end
  endfunction

  // predictor: follows accepted config writes and haystack beats
  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) needle_words[k] = '0;
      needle_len = bss_pkg::NEEDLE_LENGTH_RST;
      clear_search_state();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index <= bss_pkg::CFG_NEEDLE_WORD_3)
          needle_words[cfg_index - bss_pkg::CFG_NEEDLE_WORD_0] = cfg_data;
        else if (cfg_index == bss_pkg::CFG_NEEDLE_LENGTH)
          needle_len = cfg_data[bss_pkg::LEN_W-1:0];
      end
      if (in_valid && !in_stall) begin
        search_byte(haystack_byte, is_last);
        accepted_count++;
      end
    end
  end

  // haystack driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (haystack_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = haystack_q.pop_front();
        in_valid      <= 1'b1;
        haystack_byte <= next_beat.data;
        is_last       <= next_beat.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // report monitor and output stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected report: found %0d match_offset %0d", found, match_offset);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            mismatch_count++;
          end
          if (match_offset !== want.match_offset) begin
            $error("match_offset: expected %0d, got %0d", want.match_offset, match_offset);
            mismatch_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_given != hold_asked) begin
        hold_given++;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic push_beat(input logic [bss_pkg::BYTE_W-1:0] b, input logic last);
    beat_t t;
    t.data = b;
    t.last = last;
    haystack_q.push_back(t);
    items_sent++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (accepted_count != items_sent || expected_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [bss_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bss_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_needle(input logic [NEEDLE_W-1:0] bits, input int len);
    logic [bss_pkg::CFG_DATA_W-1:0] len_word;
    gen_bits = bits;
    gen_len  = len;
    for (int k = 0; k < 4; k++)
      cfg_write(bss_pkg::CFG_NEEDLE_WORD_0 + bss_pkg::CFG_INDEX_W'(k),
                bits[bss_pkg::CFG_DATA_W*k +: bss_pkg::CFG_DATA_W]);
    len_word = {$urandom, $urandom};
    len_word[bss_pkg::LEN_W-1:0] = bss_pkg::LEN_W'(len);
    cfg_write(bss_pkg::CFG_NEEDLE_LENGTH, len_word);
    if ($urandom_range(3) == 0)
      cfg_write(bss_pkg::CFG_INDEX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                {$urandom, $urandom});
  endtask

  task automatic random_needle();
    logic [NEEDLE_W-1:0]        bits;
    logic [bss_pkg::BYTE_W-1:0] alpha [4];
    int                         r;
    int                         len;
    r = $urandom_range(99);
    if (r < 8) len = 0;
    else if (r < 16) len = bss_pkg::NEEDLE_MAX_DEF;
    else if (r < 22) len = $urandom_range(LEN_TOP, bss_pkg::NEEDLE_MAX_DEF + 1);
    else if (r < 30) len = 1;
    else len = $urandom_range(12, 2);
    alpha[0] = '0;
    alpha[1] = '1;
    alpha[2] = bss_pkg::BYTE_W'($urandom);
    alpha[3] = bss_pkg::BYTE_W'($urandom);
    if ($urandom_range(1) == 0) begin
      for (int i = 0; i < bss_pkg::NEEDLE_MAX_DEF; i++)
        bits[bss_pkg::BYTE_W*i +: bss_pkg::BYTE_W] = alpha[$urandom_range(3)];
    end else begin
      for (int w = 0; w < NEEDLE_W / 32; w++) bits[32*w +: 32] = $urandom;
    end
    load_needle(bits, len);
  endtask

  task automatic random_haystack();
    logic [bss_pkg::BYTE_W-1:0] hay [];
    int                         n;
    int                         pos;
    int                         k;
    bit                         usable;
    bit                         plant;
    bit                         alpha_mode;
    usable = (gen_len >= 1 && gen_len <= bss_pkg::NEEDLE_MAX_DEF);
    n = ($urandom_range(9) == 0) ? $urandom_range(70, 25) : $urandom_range(24, 1);
    plant = usable && ($urandom_range(99) < 60);
    if (plant && n < gen_len) n = gen_len + $urandom_range(3);
    alpha_mode = ($urandom_range(99) < 70);
    hay = new[n];
    for (int i = 0; i < n; i++) begin
      if (alpha_mode) begin
        k = usable ? $urandom_range(gen_len - 1) : $urandom_range(bss_pkg::NEEDLE_MAX_DEF - 1);
        hay[i] = gen_bits[bss_pkg::BYTE_W*k +: bss_pkg::BYTE_W];
      end else begin
        hay[i] = bss_pkg::BYTE_W'($urandom);
      end
    end
    if (plant) begin
      pos = $urandom_range(n - gen_len);
      for (int j = 0; j < gen_len; j++)
        hay[pos+j] = gen_bits[bss_pkg::BYTE_W*j +: bss_pkg::BYTE_W];
    end
    if (n > 1 && $urandom_range(19) == 0) begin
      // needle swap partway through the haystack
      for (int i = 0; i < n / 2; i++) push_beat(hay[i], 1'b0);
      wait_drained();
      random_needle();
      for (int i = n / 2; i < n; i++) push_beat(hay[i], i == n - 1);
    end else begin
      for (int i = 0; i < n; i++) push_beat(hay[i], i == n - 1);
    end
  endtask

  initial begin : main_seq
    logic [NEEDLE_W-1:0]        bits;
    logic [bss_pkg::BYTE_W-1:0] abc_seq [7];
    int                         base;
    rst           = 1'b1;
    in_valid      = 1'b0;
    haystack_byte = '0;
    is_last       = 1'b0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    gen_bits      = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset needle is one zero byte
    push_beat(8'hFF, 1'b0);
    push_beat(8'h00, 1'b1);
    wait_drained();

    // empty needle hits at offset zero
    for (int w = 0; w < NEEDLE_W / 32; w++) bits[32*w +: 32] = $urandom;
    load_needle(bits, 0);
    push_beat(8'hAB, 1'b1);
    wait_drained();

    // needle longer than the window never hits
    bits = '0;
    load_needle(bits, bss_pkg::NEEDLE_MAX_DEF + 8);
    push_beat(8'h00, 1'b1);
    wait_drained();

    // short haystack, then first of two hits
    bits = '0;
    bits[23:0] = 24'h434241;
    load_needle(bits, 3);
    push_beat(8'h41, 1'b0);
    push_beat(8'h42, 1'b1);
    abc_seq = '{8'h78, 8'h41, 8'h42, 8'h43, 8'h41, 8'h42, 8'h43};
    foreach (abc_seq[i]) push_beat(abc_seq[i], i == 6);
    wait_drained();

    // needle change mid haystack keeps the recorded hit
    bits = '0;
    bits[15:0] = 16'h4544;
    load_needle(bits, 2);
    push_beat(8'h44, 1'b0);
    push_beat(8'h45, 1'b0);
    wait_drained();
    bits = '0;
    bits[7:0] = 8'h51;
    load_needle(bits, 1);
    push_beat(8'h51, 1'b1);
    wait_drained();

    base = items_sent;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          // long output hold while short haystacks keep coming
          wait_drained();
          hold_asked++;
          for (int i = 0; i < 24; i++) begin
            push_beat(bss_pkg::BYTE_W'($urandom), 1'b0);
            push_beat(bss_pkg::BYTE_W'($urandom), 1'b1);
          end
          wait_drained();
        end
      endcase
      random_needle();
      while (items_sent < base + RUN_ITEMS * (ph + 1) / 3) begin
        if ($urandom_range(7) == 0) begin
          wait_drained();
          random_needle();
        end
        random_haystack();
      end
      wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bss_pkg.sv
hw/rtl/bss_match.sv
hw/rtl/byte_string_search_top.sv
hw/rtl/bss_checker.sv
verif/byte_string_search_top_test.sv
